// ===== rtl/osq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// osq_pkg: shared types and constants of the obstacle avoidance sequencer
// Mode, drive and register index codes, the item and result records and the
// constants of the avoidance sequence.
// ----------------------------------------------------------------------------
package osq_pkg;

	// Sequencer modes, one-hot.
	typedef enum logic [8:0] {
		M_FORWARD = 9'b000000001,
		M_STOP    = 9'b000000010,
		M_LEFT    = 9'b000000100,
		M_PASS    = 9'b000001000,
		M_FIND    = 9'b000010000,
		M_PAUSE   = 9'b000100000,
		M_FAULT   = 9'b001000000,
		M_TIMEOUT = 9'b010000000,
		M_MANUAL  = 9'b100000000
	} mode_t;

	// Mode codes as reported on the result item.
	localparam logic [3:0] CODE_FORWARD = 4'd0;
	localparam logic [3:0] CODE_STOP    = 4'd1;
	localparam logic [3:0] CODE_LEFT    = 4'd2;
	localparam logic [3:0] CODE_PASS    = 4'd3;
	localparam logic [3:0] CODE_FIND    = 4'd4;
	localparam logic [3:0] CODE_PAUSE   = 4'd5;
	localparam logic [3:0] CODE_FAULT   = 4'd6;
	localparam logic [3:0] CODE_TIMEOUT = 4'd7;
	localparam logic [3:0] CODE_MANUAL  = 4'd8;

	// Drive commands.
	typedef enum logic [1:0] {
		D_STOP  = 2'd0,
		D_FWD   = 2'd1,
		D_LEFT  = 2'd2,
		D_RIGHT = 2'd3
	} drive_t;

	// Configuration register indexes.
	localparam logic [3:0] REG_OBSTACLE  = 4'd0;
	localparam logic [3:0] REG_EMERGENCY = 4'd1;
	localparam logic [3:0] REG_REARM     = 4'd2;
	localparam logic [3:0] REG_STOP_HOLD = 4'd3;
	localparam logic [3:0] REG_STRAFE    = 4'd4;
	localparam logic [3:0] REG_PASS      = 4'd5;
	localparam logic [3:0] REG_BACK_MIN  = 4'd6;
	localparam logic [3:0] REG_BACK_MAX  = 4'd7;

	// Sequence constants.
	localparam logic [3:0]        CENTER_MASK  = 4'h6;
	localparam logic [1:0]        NEAR_CONFIRM = 2'd2;
	localparam logic [1:0]        BAD_LIMIT    = 2'd3;
	localparam logic [1:0]        LINE_CONFIRM = 2'd3;
	localparam logic [2:0]        FAR_CONFIRM  = 3'd5;
	localparam logic [15:0]       PAUSE_MS     = 16'd120;
	localparam logic signed [7:0] FWD_LEFT_CMD  = 8'sd45;
	localparam logic signed [7:0] FWD_RIGHT_CMD = -8'sd49;
	localparam logic signed [7:0] STRAFE_L_CMD  = 8'sd41;
	localparam logic signed [7:0] STRAFE_R_CMD  = -8'sd41;

	typedef struct packed {
		logic [9:0]  obstacle_mm;
		logic [9:0]  emergency_mm;
		logic [9:0]  rearm_mm;
		logic [15:0] stop_hold_ms;
		logic [15:0] strafe_left_ms;
		logic [15:0] pass_ms;
		logic [15:0] back_min_ms;
		logic [15:0] back_max_ms;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        run;
		logic        armed;
		logic [1:0]  near_cnt;
		logic [1:0]  bad_cnt;
		logic [2:0]  far_cnt;
		logic [1:0]  line_cnt;
		logic [15:0] mode_time_ms;
	} state_t;

	typedef struct packed {
		logic [7:0]         tick_ms;
		logic               button_press;
		logic               sample_valid;
		logic signed [10:0] range_mm;
		logic [3:0]         line_bits;
	} item_t;

	typedef struct packed {
		logic [3:0]        mode_code;
		logic              is_running;
		logic              is_armed;
		drive_t            drive_kind;
		logic signed [7:0] left_cmd;
		logic signed [7:0] right_cmd;
		logic signed [7:0] rear_cmd;
	} result_t;

	// Reported code of a mode.
	function automatic logic [3:0] mode_code(input mode_t m);
		logic [3:0] c;
		case (m)
			M_FORWARD: c = CODE_FORWARD;
			M_STOP:    c = CODE_STOP;
			M_LEFT:    c = CODE_LEFT;
			M_PASS:    c = CODE_PASS;
			M_FIND:    c = CODE_FIND;
			M_PAUSE:   c = CODE_PAUSE;
			M_FAULT:   c = CODE_FAULT;
			M_TIMEOUT: c = CODE_TIMEOUT;
			default:   c = CODE_MANUAL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/osq_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// osq_cfg_regs: configuration register file
// Holds the distance thresholds and mode durations, written one register per
// accepted write; indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module osq_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [3:0]    wr_addr,
	input  wire logic [15:0]   wr_data,
	output osq_pkg::cfg_t      cfg
);

	osq_pkg::cfg_t cfg_q;

	// Register writes; reset loads the default thresholds and durations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_mm    <= 10'd90;
			cfg_q.emergency_mm   <= 10'd60;
			cfg_q.rearm_mm       <= 10'd150;
			cfg_q.stop_hold_ms   <= 16'd120;
			cfg_q.strafe_left_ms <= 16'd900;
			cfg_q.pass_ms        <= 16'd1200;
			cfg_q.back_min_ms    <= 16'd250;
			cfg_q.back_max_ms    <= 16'd2600;
		end else if (wr_en) begin
			case (wr_addr)
				osq_pkg::REG_OBSTACLE:  cfg_q.obstacle_mm    <= wr_data[9:0];
				osq_pkg::REG_EMERGENCY: cfg_q.emergency_mm   <= wr_data[9:0];
				osq_pkg::REG_REARM:     cfg_q.rearm_mm       <= wr_data[9:0];
				osq_pkg::REG_STOP_HOLD: cfg_q.stop_hold_ms   <= wr_data;
				osq_pkg::REG_STRAFE:    cfg_q.strafe_left_ms <= wr_data;
				osq_pkg::REG_PASS:      cfg_q.pass_ms        <= wr_data;
				osq_pkg::REG_BACK_MIN:  cfg_q.back_min_ms    <= wr_data;
				osq_pkg::REG_BACK_MAX:  cfg_q.back_max_ms    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/osq_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// osq_step: next-state and result logic for one control step
// Applies the timer, the button, the distance sample and the mode action to
// the current state and forms the drive command of the step.
// ----------------------------------------------------------------------------
module osq_step (
	input  wire osq_pkg::cfg_t     cfg,
	input  wire osq_pkg::state_t   cur,
	input  wire osq_pkg::item_t    item,
	output osq_pkg::state_t        nxt,
	output osq_pkg::result_t       res
);

	// Mode change; the timer clears only when the mode really changes.
	function automatic osq_pkg::state_t go_mode(input osq_pkg::state_t st,
			input osq_pkg::mode_t m);
		osq_pkg::state_t r;
		r = st;
		if (st.mode != m) begin
			r.mode = m;
			r.mode_time_ms = '0;
		end
		return r;
	endfunction

	// Saturating increment of a two-bit counter.
	function automatic logic [1:0] inc2(input logic [1:0] v);
		return (v == 2'd3) ? v : v + 2'd1;
	endfunction

	always_comb begin
		osq_pkg::state_t s;
		osq_pkg::drive_t drv;
		logic [16:0]     sum;
		logic [15:0]     el;
		logic [9:0]      sample_mm;

		s         = cur;
		drv       = osq_pkg::D_STOP;
		sample_mm = item.range_mm[9:0];

		// Mode timer, saturating.
		sum = {1'b0, cur.mode_time_ms} + {9'd0, item.tick_ms};
		s.mode_time_ms = sum[16] ? 16'hFFFF : sum[15:0];

		// Start/stop button.
		if (item.button_press) begin
			if (s.run) begin
				s.run = 1'b0;
				s = go_mode(s, osq_pkg::M_MANUAL);
			end else begin
				s.run      = 1'b1;
				s.armed    = 1'b1;
				s.near_cnt = '0;
				s.bad_cnt  = '0;
				s.far_cnt  = '0;
				s.line_cnt = '0;
				s = go_mode(s, osq_pkg::M_FORWARD);
			end
		end

		// Distance sample, only taken while driving forward.
		if (s.run && s.mode == osq_pkg::M_FORWARD && item.sample_valid) begin
			if (item.range_mm[10]) begin
				s.near_cnt = '0;
				s.bad_cnt  = inc2(s.bad_cnt);
				if (s.bad_cnt >= osq_pkg::BAD_LIMIT) begin
					s.run = 1'b0;
					s = go_mode(s, osq_pkg::M_FAULT);
				end
			end else begin
				s.bad_cnt = '0;
				if (!s.armed) begin
					if (sample_mm >= cfg.rearm_mm) begin
						s.far_cnt = (s.far_cnt == 3'd7) ? s.far_cnt : s.far_cnt + 3'd1;
						if (s.far_cnt >= osq_pkg::FAR_CONFIRM) begin
							s.armed   = 1'b1;
							s.far_cnt = '0;
						end
					end else begin
						s.far_cnt = '0;
					end
				end else if (sample_mm <= cfg.emergency_mm) begin
					s = go_mode(s, osq_pkg::M_STOP);
					s.near_cnt = '0;
				end else if (sample_mm <= cfg.obstacle_mm) begin
					s.near_cnt = inc2(s.near_cnt);
					if (s.near_cnt >= osq_pkg::NEAR_CONFIRM) begin
						s = go_mode(s, osq_pkg::M_STOP);
						s.near_cnt = '0;
					end
				end else begin
					s.near_cnt = '0;
				end
			end
		end

		// Mode action and timed transitions.
		el = s.mode_time_ms;
		if (s.run) begin
			case (s.mode)
				osq_pkg::M_FORWARD: begin
					drv = osq_pkg::D_FWD;
				end
				osq_pkg::M_STOP: begin
					if (el >= cfg.stop_hold_ms) s = go_mode(s, osq_pkg::M_LEFT);
				end
				osq_pkg::M_LEFT: begin
					drv = osq_pkg::D_LEFT;
					if (el >= cfg.strafe_left_ms) s = go_mode(s, osq_pkg::M_PASS);
				end
				osq_pkg::M_PASS: begin
					drv = osq_pkg::D_FWD;
					if (el >= cfg.pass_ms) begin
						s.line_cnt = '0;
						s = go_mode(s, osq_pkg::M_FIND);
					end
				end
				osq_pkg::M_FIND: begin
					drv = osq_pkg::D_RIGHT;
					if (el >= cfg.back_min_ms &&
							(item.line_bits & osq_pkg::CENTER_MASK) != 4'd0) begin
						s.line_cnt = inc2(s.line_cnt);
						if (s.line_cnt >= osq_pkg::LINE_CONFIRM) begin
							drv = osq_pkg::D_STOP;
							s = go_mode(s, osq_pkg::M_PAUSE);
						end
					end else begin
						s.line_cnt = '0;
					end
					// Timeout counts only when the line was not found this step.
					if (s.mode == osq_pkg::M_FIND && el >= cfg.back_max_ms) begin
						s.run = 1'b0;
						drv   = osq_pkg::D_STOP;
						s = go_mode(s, osq_pkg::M_TIMEOUT);
					end
				end
				osq_pkg::M_PAUSE: begin
					if (el >= osq_pkg::PAUSE_MS) begin
						s.armed   = 1'b0;
						s.far_cnt = '0;
						s = go_mode(s, osq_pkg::M_FORWARD);
					end
				end
				default: ;
			endcase
		end

		nxt = s;

		// Result item: state after the step and the wheel commands.
		res.mode_code  = osq_pkg::mode_code(s.mode);
		res.is_running = s.run;
		res.is_armed   = s.armed;
		res.drive_kind = drv;
		res.left_cmd   = '0;
		res.right_cmd  = '0;
		res.rear_cmd   = '0;
		case (drv)
			osq_pkg::D_FWD: begin
				res.left_cmd  = osq_pkg::FWD_LEFT_CMD;
				res.right_cmd = osq_pkg::FWD_RIGHT_CMD;
			end
			osq_pkg::D_LEFT:  res.rear_cmd = osq_pkg::STRAFE_L_CMD;
			osq_pkg::D_RIGHT: res.rear_cmd = osq_pkg::STRAFE_R_CMD;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/obstacle_avoid_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer: obstacle avoidance control sequencer
// Takes one control step per input item and returns the mode, flags and
// wheel commands of that step as one result item.
//
//   Channel   Direction  Handshake               Payload
//   s_*       in         s_tvalid / s_tready     step inputs (tdata, tuser)
//   m_*       out        m_tvalid / m_tready     step result (tdata, tuser)
//   cfg_*     in         cfg_valid / cfg_ready   register index and value
//
// An item is registered on acceptance; its result loads when the result register
// frees. One item per cycle is sustained while results are taken: the step logic
// sits between the input and result registers and the sequencer state updates as
// the result is loaded. A stalled result register holds; the input register still
// takes an item when the result register frees in the same cycle.
// Reset clears the sequencer state to manual stop and loads default registers.
// ----------------------------------------------------------------------------
module obstacle_avoid_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] tick_ms, [8] button_press, [19:9] range_mm, [23:20] line_bits
	input  wire logic [23:0] s_tdata,
	// [0] sample_valid
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [3:0] mode_code, [4] is_running, [5] is_armed, [13:6] left_cmd,
	// [21:14] right_cmd, [29:22] rear_cmd, [31:30] zero
	output logic [31:0]      m_tdata,
	// [1:0] drive_kind
	output logic [1:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);

	osq_pkg::cfg_t    cfg;
	osq_pkg::item_t   item_s1;
	logic             valid_s1;
	osq_pkg::state_t  state_q;
	osq_pkg::state_t  state_nxt;
	osq_pkg::result_t res_nxt;
	osq_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;

	// Configuration registers take every write.
	assign cfg_ready = 1'b1;

	osq_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// Handshake: the registered item moves on when the result register frees.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.tick_ms      <= s_tdata[7:0];
			item_s1.button_press <= s_tdata[8];
			item_s1.range_mm     <= s_tdata[19:9];
			item_s1.line_bits    <= s_tdata[23:20];
			item_s1.sample_valid <= s_tuser;
		end
	end

	osq_step u_step (
		.cfg  (cfg),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= osq_pkg::M_MANUAL;
			state_q.run          <= 1'b0;
			state_q.armed        <= 1'b1;
			state_q.near_cnt     <= '0;
			state_q.bad_cnt      <= '0;
			state_q.far_cnt      <= '0;
			state_q.line_cnt     <= '0;
			state_q.mode_time_ms <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.rear_cmd, res_s2.right_cmd, res_s2.left_cmd,
		res_s2.is_armed, res_s2.is_running, res_s2.mode_code};
	assign m_tuser  = res_s2.drive_kind;

`ifndef SYNTHESIS
	// The sequence stops only into fault, timeout or manual stop.
	a_stopped_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.run |-> (state_q.mode == osq_pkg::M_FAULT ||
			state_q.mode == osq_pkg::M_TIMEOUT || state_q.mode == osq_pkg::M_MANUAL))
		else $error("stopped sequencer in an active mode");

	// Input is refused only while an item waits behind a stalled result.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input refused without an output stall");

	// The far and near confirmation counters clear when they reach their limit.
	a_count_limits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.far_cnt < osq_pkg::FAR_CONFIRM && state_q.near_cnt < osq_pkg::NEAR_CONFIRM)
		else $error("confirmation counter past its limit");

	// A result taken with no new one behind it leaves the output empty.
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !advance) |=> !m_tvalid)
		else $error("result repeated after acceptance");
`endif

endmodule
`default_nettype wire
